@@ sv/bor_pkg.sv @@
// ----------------------------------------------------------------------------
// bor_pkg
// Types, sizes and codes shared by the broadcast ring front, queue and back.
// ----------------------------------------------------------------------------
package bor_pkg;

  localparam int DEPTH       = 16;
  localparam int SUBSCRIBERS = 4;
  localparam int INDEX_BITS  = 32;

  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUB_W     = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int PAYLOAD_W = 64;
  localparam int BYTES_W   = 4;
  localparam int KIND_W    = 2;
  localparam int SEL_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int DROP_W    = 32;
  localparam int MAX_BYTES = 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_PUBLISH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DELIVERED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_REJECT    = 2'd3
  } status_t;

  // classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_PUBLISH,
    OP_BEGIN,
    OP_READ,
    OP_REJECT,
    OP_NOP,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [SUB_W-1:0]     sub;
    logic [BYTES_W-1:0]   nbytes;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef enum logic {
    BK_EXEC,
    BK_FETCH
  } bk_state_t;

  function automatic logic [PAYLOAD_W-1:0] byte_mask(logic [BYTES_W-1:0] n);
    logic [PAYLOAD_W-1:0] m;
    if (n >= BYTES_W'(MAX_BYTES)) begin
      m = '1;
    end else begin
      m = (PAYLOAD_W'(1) << {n, 3'b000}) - PAYLOAD_W'(1);
    end
    return m;
  endfunction

  function automatic logic [DROP_W-1:0] sat_drop(logic [INDEX_BITS-1:0] d);
    logic [63:0] wide;
    wide = 64'(d);
    return (|wide[63:DROP_W]) ? '1 : wide[DROP_W-1:0];
  endfunction

endpackage

@@ sv/bor_in_if.sv @@
// ----------------------------------------------------------------------------
// bor_in_if
// Request channel: operation kind, subscriber, size and payload.
// ----------------------------------------------------------------------------
interface bor_in_if;
  import bor_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SEL_W-1:0]     subscriber;
  logic [BYTES_W-1:0]   message_bytes;
  logic [PAYLOAD_W-1:0] payload_in;

  modport source (output valid, kind, subscriber, message_bytes, payload_in, input ready);
  modport sink   (input valid, kind, subscriber, message_bytes, payload_in, output ready);
endinterface

@@ sv/bor_out_if.sv @@
// ----------------------------------------------------------------------------
// bor_out_if
// Result channel: status and, for a delivery, payload, size and drop count.
// ----------------------------------------------------------------------------
interface bor_out_if;
  import bor_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [BYTES_W-1:0]   bytes_out;
  logic [DROP_W-1:0]    dropped;

  modport source (output valid, status, payload_out, bytes_out, dropped, input ready);
  modport sink   (input valid, status, payload_out, bytes_out, dropped, output ready);
endinterface

@@ sv/bor_front.sv @@
// ----------------------------------------------------------------------------
// bor_front
// Accepts request words, holds the size limit and classifies each word.
// ----------------------------------------------------------------------------
module bor_front (
  input  logic                    clk,
  input  logic                    rst_n,
  bor_in_if.sink                  in_ch,
  input  logic                    cfg_wr_en,
  input  logic [bor_pkg::BYTES_W-1:0] cfg_wr_data,
  input  logic                    q_full,
  output logic                    push,
  output bor_pkg::cmd_t           cmd
);
  import bor_pkg::*;

  logic [BYTES_W-1:0] max_bytes_r;
  logic               sub_ok;
  logic               too_big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= BYTES_W'(MAX_BYTES);
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign sub_ok  = int'(in_ch.subscriber) < SUBSCRIBERS;
  assign too_big = (in_ch.message_bytes > max_bytes_r) ||
                   (in_ch.message_bytes > BYTES_W'(MAX_BYTES));

  always_comb begin
    cmd.sub     = SUB_W'(in_ch.subscriber);
    cmd.nbytes  = in_ch.message_bytes;
    cmd.payload = in_ch.payload_in & byte_mask(in_ch.message_bytes);
    unique case (in_ch.kind)
      KIND_PUBLISH: cmd.op = too_big ? OP_REJECT : OP_PUBLISH;
      KIND_BEGIN:   cmd.op = sub_ok ? OP_BEGIN : OP_NOP;
      KIND_READ:    cmd.op = sub_ok ? OP_READ : OP_EMPTY;
      default:      cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ sv/bor_queue.sv @@
// ----------------------------------------------------------------------------
// bor_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bor_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bor_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output bor_pkg::cmd_t cmd_out,
  output logic          empty
);
  import bor_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign cmd_out = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ sv/bor_back.sv @@
// ----------------------------------------------------------------------------
// bor_back
// Executes commands against head, tail, cursors and the slot memory, and
// holds the result register.
// ----------------------------------------------------------------------------
module bor_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bor_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          pop,
  bor_out_if.source     out_ch
);
  import bor_pkg::*;

  localparam int SLOT_DW = BYTES_W + PAYLOAD_W;

  bk_state_t state_r, state_nxt;

  logic [INDEX_BITS-1:0] head_r, head_nxt;
  logic [INDEX_BITS-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0]     head_slot_r, head_slot_nxt;
  logic [SLOT_W-1:0]     tail_slot_r, tail_slot_nxt;
  logic [INDEX_BITS-1:0] cursor_r [SUBSCRIBERS];
  logic [INDEX_BITS-1:0] cursor_nxt [SUBSCRIBERS];
  logic [SLOT_W-1:0]     cslot_r [SUBSCRIBERS];
  logic [SLOT_W-1:0]     cslot_nxt [SUBSCRIBERS];

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [PAYLOAD_W-1:0]  out_payload_r, out_payload_nxt;
  logic [BYTES_W-1:0]    out_bytes_r, out_bytes_nxt;
  logic [DROP_W-1:0]     out_drop_r, out_drop_nxt;
  logic [DROP_W-1:0]     drop_r, drop_nxt;

  logic [SLOT_DW-1:0]    mem [DEPTH];
  logic [SLOT_DW-1:0]    rd_data_r;
  logic                  mem_we;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;

  logic [INDEX_BITS-1:0] c;
  logic [SLOT_W-1:0]     cs;
  logic [INDEX_BITS-1:0] drops;
  logic                  deliver;

  function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.payload_out = out_payload_r;
  assign out_ch.bytes_out   = out_bytes_r;
  assign out_ch.dropped     = out_drop_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    head_slot_nxt   = head_slot_r;
    tail_slot_nxt   = tail_slot_r;
    cursor_nxt      = cursor_r;
    cslot_nxt       = cslot_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_bytes_nxt   = out_bytes_r;
    out_drop_nxt    = out_drop_r;
    drop_nxt        = drop_r;
    pop             = 1'b0;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    c               = cursor_r[q_cmd.sub];
    cs              = cslot_r[q_cmd.sub];
    drops           = '0;
    deliver         = 1'b0;

    unique case (state_r)
      BK_EXEC: begin
        if (!q_empty && (!out_valid_r || out_ch.ready)) begin
          pop             = 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_DONE;
          out_payload_nxt = '0;
          out_bytes_nxt   = '0;
          out_drop_nxt    = '0;
          unique case (q_cmd.op)
            OP_PUBLISH: begin
              mem_we = 1'b1;
              // slot at the tail still live: drop the oldest entry
              if ((tail_r - head_r) == INDEX_BITS'(DEPTH)) begin
                head_nxt      = head_r + INDEX_BITS'(1);
                head_slot_nxt = slot_inc(head_slot_r);
              end
              tail_nxt      = tail_r + INDEX_BITS'(1);
              tail_slot_nxt = slot_inc(tail_slot_r);
            end
            OP_BEGIN: begin
              cursor_nxt[q_cmd.sub] = head_r;
              cslot_nxt[q_cmd.sub]  = head_slot_r;
            end
            OP_READ: begin
              if (c == tail_r) begin
                out_status_nxt = ST_EMPTY;
              end else if (c < head_r) begin
                // cursor was overrun: jump to the head
                if (head_r == tail_r) begin
                  cursor_nxt[q_cmd.sub] = head_r;
                  cslot_nxt[q_cmd.sub]  = head_slot_r;
                  out_status_nxt        = ST_EMPTY;
                end else begin
                  drops   = head_r - c;
                  c       = head_r;
                  cs      = head_slot_r;
                  deliver = 1'b1;
                end
              end else begin
                deliver = 1'b1;
              end
              if (deliver) begin
                cursor_nxt[q_cmd.sub] = c + INDEX_BITS'(1);
                cslot_nxt[q_cmd.sub]  = slot_inc(cs);
                rd_en                 = 1'b1;
                rd_addr               = cs;
                drop_nxt              = sat_drop(drops);
                out_valid_nxt         = 1'b0;
                state_nxt             = BK_FETCH;
              end
            end
            OP_REJECT: out_status_nxt = ST_REJECT;
            OP_EMPTY:  out_status_nxt = ST_EMPTY;
            OP_NOP:    out_status_nxt = ST_DONE;
            default:   out_status_nxt = ST_DONE;
          endcase
        end
      end
      BK_FETCH: begin
        // result register is free here: it was drained when the read left
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_DELIVERED;
        out_payload_nxt = rd_data_r[PAYLOAD_W-1:0];
        out_bytes_nxt   = rd_data_r[SLOT_DW-1:PAYLOAD_W];
        out_drop_nxt    = drop_r;
        state_nxt       = BK_EXEC;
      end
      default: state_nxt = BK_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      head_r      <= INDEX_BITS'(1);
      tail_r      <= INDEX_BITS'(1);
      head_slot_r <= SLOT_W'(1 % DEPTH);
      tail_slot_r <= SLOT_W'(1 % DEPTH);
      out_valid_r <= 1'b0;
      for (int i = 0; i < SUBSCRIBERS; i++) begin
        cursor_r[i] <= INDEX_BITS'(1);
        cslot_r[i]  <= SLOT_W'(1 % DEPTH);
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      head_slot_r <= head_slot_nxt;
      tail_slot_r <= tail_slot_nxt;
      out_valid_r <= out_valid_nxt;
      cursor_r    <= cursor_nxt;
      cslot_r     <= cslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_bytes_r   <= out_bytes_nxt;
    out_drop_r    <= out_drop_nxt;
    drop_r        <= drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_slot_r] <= {q_cmd.nbytes, q_cmd.payload};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ sv/broadcast_overwrite_ring_top.sv @@
// ----------------------------------------------------------------------------
// broadcast_overwrite_ring_top
// Overwriting broadcast ring: one publisher, several subscriber cursors.
// ----------------------------------------------------------------------------
// Request words enter a two-word queue, so in_ch.ready stays high while the
// queue has room. The execute stage completes a publish, a begin, a rejected
// or an empty request; a delivered read also passes the fetch state, as the
// slot memory read is registered, and no word is popped meanwhile. The rate
// is one word per cycle for publishes and begins while results are taken.
// Results leave through a registered output that, but for a delivered read,
// is refilled in the cycle it is taken. No clearing pass runs after reset.
module broadcast_overwrite_ring_top (
  input  logic                        clk,
  input  logic                        rst_n,
  bor_in_if.sink                      in_ch,
  bor_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [bor_pkg::BYTES_W-1:0] cfg_wr_data
);
  import bor_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  bor_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .cmd         (front_cmd)
  );

  bor_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (pop),
    .cmd_out (q_cmd),
    .empty   (q_empty)
  );

  bor_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ sv/bor_checker.sv @@
// ----------------------------------------------------------------------------
// bor_checker
// Port-level checks on the result channel of the broadcast ring.
// ----------------------------------------------------------------------------
module bor_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bor_pkg::STATUS_W-1:0] status,
  input logic [bor_pkg::PAYLOAD_W-1:0] payload_out,
  input logic [bor_pkg::BYTES_W-1:0]  bytes_out,
  input logic [bor_pkg::DROP_W-1:0]   dropped
);
  import bor_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(payload_out) && $stable(bytes_out) && $stable(dropped))
    else $error("stalled result word changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DELIVERED |->
      payload_out == '0 && bytes_out == '0 && dropped == '0)
    else $error("non-delivery word carries data");

  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_DELIVERED |-> bytes_out <= BYTES_W'(MAX_BYTES))
    else $error("delivered size above limit");

endmodule

bind broadcast_overwrite_ring_top bor_checker u_bor_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .payload_out (out_ch.payload_out),
  .bytes_out   (out_ch.bytes_out),
  .dropped     (out_ch.dropped)
);
